// ===== hw/rtl/rpa_pkg.sv =====
`timescale 1ns / 1ps

package rpa_pkg;

    // defaults for the top-level parameters
    localparam int NUM_PAGES_DEF  = 32768;
    localparam int PAGE_SHIFT_DEF = 12;
    localparam int COUNT_BITS_DEF = 8;

    // fixed field widths
    localparam int ADDR_W   = 32;
    localparam int FIRST_W  = 20;
    localparam int END_W    = 21;
    localparam int CNTOUT_W = 8;
    localparam int CNTEXT_W = 16;

    localparam logic [END_W-1:0] END_PAGE_RST = 21'd32768;

    // configuration register indexes
    localparam logic CFG_FIRST_PAGE = 1'b0;
    localparam logic CFG_END_PAGE   = 1'b1;

    typedef enum logic [1:0] {
        CMD_INIT  = 2'd0,
        CMD_ALLOC = 2'd1,
        CMD_FREE  = 2'd2,
        CMD_INC   = 2'd3
    } t_cmd;

    typedef enum logic [1:0] {
        STS_OK      = 2'd0,
        STS_BADADDR = 2'd1,
        STS_ZERO    = 2'd2,
        STS_EMPTY   = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        S_CLEAR,
        S_IDLE,
        S_EXEC,
        S_INIT
    } t_state;

endpackage

// ===== hw/rtl/rpa_front.sv =====
`timescale 1ns / 1ps

// Config registers and command classification (range and alignment checks).
module rpa_front #(
    parameter int NUM_PAGES  = rpa_pkg::NUM_PAGES_DEF,
    parameter int PAGE_SHIFT = rpa_pkg::PAGE_SHIFT_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic                        i_cfg_idx,
    input  logic [rpa_pkg::END_W-1:0]   i_cfg_data,
    input  logic [1:0]                  i_cmd,
    input  logic [rpa_pkg::ADDR_W-1:0]  i_phys_addr,
    output logic [1:0]                  o_cmd,
    output logic                        o_bad,
    output logic [$clog2(NUM_PAGES)-1:0] o_pg,
    output logic [rpa_pkg::END_W-1:0]   o_first_page,
    output logic [rpa_pkg::END_W-1:0]   o_lim
);

    localparam int PGW = $clog2(NUM_PAGES);
    localparam logic [rpa_pkg::ADDR_W-1:0] OFS_MASK =
        rpa_pkg::ADDR_W'((64'd1 << PAGE_SHIFT) - 64'd1);

    logic [rpa_pkg::FIRST_W-1:0] r_first_page;
    logic [rpa_pkg::END_W-1:0]   r_end_page;
    logic [rpa_pkg::ADDR_W-1:0]  pg_full;
    logic                        in_rng;
    logic                        aligned;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_first_page <= '0;
            r_end_page   <= rpa_pkg::END_PAGE_RST;
        end else if (i_cfg_we) begin
            if (i_cfg_idx == rpa_pkg::CFG_FIRST_PAGE) begin
                r_first_page <= i_cfg_data[rpa_pkg::FIRST_W-1:0];
            end else begin
                r_end_page <= i_cfg_data;
            end
        end
    end

    // limit = min(end_page, NUM_PAGES)
    assign o_lim = (r_end_page < rpa_pkg::END_W'(NUM_PAGES)) ?
                   r_end_page : rpa_pkg::END_W'(NUM_PAGES);
    assign o_first_page = rpa_pkg::END_W'(r_first_page);

    assign pg_full = i_phys_addr >> PAGE_SHIFT;
    assign in_rng  = (pg_full >= rpa_pkg::ADDR_W'(r_first_page)) &&
                     (pg_full < rpa_pkg::ADDR_W'(o_lim));
    assign aligned = (i_phys_addr & OFS_MASK) == '0;

    always_comb begin
        o_cmd = i_cmd;
        o_pg  = pg_full[PGW-1:0];   // in range implies below NUM_PAGES
        if (i_cmd == rpa_pkg::CMD_FREE) begin
            o_bad = !aligned || !in_rng;
        end else begin
            o_bad = !in_rng;
        end
    end

endmodule

// ===== hw/rtl/rpa_queue.sv =====
`timescale 1ns / 1ps

// Two-entry FIFO between classifier and executor.
module rpa_queue #(
    parameter int W = 4
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_push,
    input  logic [W-1:0] i_data,
    input  logic         i_pop,
    output logic [W-1:0] o_data,
    output logic         o_full,
    output logic         o_empty
);

    logic [W-1:0] r_mem [2];
    logic         r_wr;
    logic         r_rd;
    logic [1:0]   r_cnt;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= 1'b0;
            r_rd  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push) begin
                r_wr <= !r_wr;
            end
            if (i_pop) begin
                r_rd <= !r_rd;
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + 2'd1;
            end else if (i_pop && !i_push) begin
                r_cnt <= r_cnt - 2'd1;
            end
        end
    end

    assign o_data  = r_mem[r_rd];
    assign o_full  = r_cnt == 2'd2;
    assign o_empty = r_cnt == 2'd0;

endmodule

// ===== hw/rtl/rpa_back.sv =====
`timescale 1ns / 1ps

// Executor: count memory, free stack memory, init walk, result register.
module rpa_back #(
    parameter int NUM_PAGES  = rpa_pkg::NUM_PAGES_DEF,
    parameter int PAGE_SHIFT = rpa_pkg::PAGE_SHIFT_DEF,
    parameter int COUNT_BITS = rpa_pkg::COUNT_BITS_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_q_empty,
    input  logic [1:0]                   i_head_cmd,
    input  logic                         i_head_bad,
    input  logic [$clog2(NUM_PAGES)-1:0] i_head_pg,
    output logic                         o_pop,
    input  logic [rpa_pkg::END_W-1:0]    i_first_page,
    input  logic [rpa_pkg::END_W-1:0]    i_lim,
    output logic                         o_clearing,
    output logic                         o_out_valid,
    input  logic                         i_out_stall,
    output logic [1:0]                   o_status,
    output logic [rpa_pkg::ADDR_W-1:0]   o_page_addr,
    output logic                         o_released,
    output logic [rpa_pkg::CNTOUT_W-1:0] o_count_after
);

    localparam int PGW = $clog2(NUM_PAGES);
    localparam int TW  = $clog2(NUM_PAGES + 1);
    localparam logic [COUNT_BITS-1:0] CNT_MAX = '1;
    localparam logic [rpa_pkg::END_W-1:0] LAST_PAGE = rpa_pkg::END_W'(NUM_PAGES - 1);

    logic [COUNT_BITS-1:0] r_cnt_mem [NUM_PAGES];
    logic [PGW-1:0]        r_stk_mem [NUM_PAGES];
    logic [COUNT_BITS-1:0] r_cnt_rd;
    logic [PGW-1:0]        r_stk_rd;

    rpa_pkg::t_state r_state, n_state;
    logic [TW-1:0]             r_top, n_top;
    logic [rpa_pkg::END_W-1:0] r_walk, n_walk;
    logic [1:0]                r_cmd, n_cmd;
    logic                      r_bad, n_bad;
    logic [PGW-1:0]            r_pg, n_pg;

    logic                         r_out_valid;
    rpa_pkg::t_status             r_status;
    logic [rpa_pkg::ADDR_W-1:0]   r_page_addr;
    logic                         r_released;
    logic [rpa_pkg::CNTOUT_W-1:0] r_count_after;

    logic [TW-1:0]               top_m1;
    logic                        out_free;
    logic                        cnt_we;
    logic [PGW-1:0]              cnt_waddr;
    logic [COUNT_BITS-1:0]       cnt_wdata;
    logic                        stk_we;
    logic [PGW-1:0]              stk_waddr;
    logic [PGW-1:0]              stk_wdata;
    logic                        res_load;
    rpa_pkg::t_status            res_status;
    logic [rpa_pkg::ADDR_W-1:0]  res_addr;
    logic                        res_rel;
    logic [rpa_pkg::CNTOUT_W-1:0] res_cnt;
    logic [COUNT_BITS-1:0]       cnt_dec;
    logic [COUNT_BITS-1:0]       cnt_inc;
    logic [rpa_pkg::CNTEXT_W-1:0] dec_ext;
    logic [rpa_pkg::CNTEXT_W-1:0] inc_ext;
    logic [63:0]                 alloc_wide;

    assign top_m1     = r_top - TW'(1);
    assign out_free   = !r_out_valid || !i_out_stall;
    assign cnt_dec    = r_cnt_rd - COUNT_BITS'(1);
    assign cnt_inc    = (r_cnt_rd == CNT_MAX) ? r_cnt_rd : r_cnt_rd + COUNT_BITS'(1);
    assign dec_ext    = rpa_pkg::CNTEXT_W'(cnt_dec);
    assign inc_ext    = rpa_pkg::CNTEXT_W'(cnt_inc);
    assign alloc_wide = 64'(r_stk_rd) << PAGE_SHIFT;

    // memories: one write port, one registered read port each
    always_ff @(posedge i_clk) begin
        if (cnt_we) begin
            r_cnt_mem[cnt_waddr] <= cnt_wdata;
        end
        if (o_pop) begin
            r_cnt_rd <= r_cnt_mem[i_head_pg];
        end
    end

    always_ff @(posedge i_clk) begin
        if (stk_we) begin
            r_stk_mem[stk_waddr] <= stk_wdata;
        end
        if (o_pop) begin
            r_stk_rd <= r_stk_mem[top_m1[PGW-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= rpa_pkg::S_CLEAR;
            r_top   <= '0;
            r_walk  <= '0;
        end else begin
            r_state <= n_state;
            r_top   <= n_top;
            r_walk  <= n_walk;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd <= n_cmd;
        r_bad <= n_bad;
        r_pg  <= n_pg;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (res_load) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_load) begin
            r_status      <= res_status;
            r_page_addr   <= res_addr;
            r_released    <= res_rel;
            r_count_after <= res_cnt;
        end
    end

    always_comb begin
        n_state    = r_state;
        n_top      = r_top;
        n_walk     = r_walk;
        n_cmd      = r_cmd;
        n_bad      = r_bad;
        n_pg       = r_pg;
        o_pop      = 1'b0;
        cnt_we     = 1'b0;
        cnt_waddr  = r_pg;
        cnt_wdata  = '0;
        stk_we     = 1'b0;
        stk_waddr  = r_top[PGW-1:0];
        stk_wdata  = r_pg;
        res_load   = 1'b0;
        res_status = rpa_pkg::STS_OK;
        res_addr   = '0;
        res_rel    = 1'b0;
        res_cnt    = '0;
        case (r_state)
            rpa_pkg::S_CLEAR: begin
                cnt_we    = 1'b1;
                cnt_waddr = r_walk[PGW-1:0];
                if (r_walk == LAST_PAGE) begin
                    n_state = rpa_pkg::S_IDLE;
                end else begin
                    n_walk = r_walk + rpa_pkg::END_W'(1);
                end
            end
            rpa_pkg::S_IDLE: begin
                if (!i_q_empty) begin
                    o_pop = 1'b1;
                    n_cmd = i_head_cmd;
                    n_bad = i_head_bad;
                    n_pg  = i_head_pg;
                    if (i_head_cmd == rpa_pkg::CMD_INIT) begin
                        n_top   = '0;
                        n_walk  = i_first_page;
                        n_state = rpa_pkg::S_INIT;
                    end else begin
                        n_state = rpa_pkg::S_EXEC;
                    end
                end
            end
            rpa_pkg::S_EXEC: begin
                if (out_free) begin
                    res_load = 1'b1;
                    n_state  = rpa_pkg::S_IDLE;
                    case (r_cmd)
                        rpa_pkg::CMD_ALLOC: begin
                            if (r_top == '0) begin
                                res_status = rpa_pkg::STS_EMPTY;
                            end else begin
                                n_top     = top_m1;
                                cnt_we    = 1'b1;
                                cnt_waddr = r_stk_rd;
                                cnt_wdata = COUNT_BITS'(1);
                                res_addr  = alloc_wide[rpa_pkg::ADDR_W-1:0];
                                res_cnt   = rpa_pkg::CNTOUT_W'(1);
                            end
                        end
                        rpa_pkg::CMD_FREE: begin
                            if (r_bad) begin
                                res_status = rpa_pkg::STS_BADADDR;
                            end else if (r_cnt_rd == '0) begin
                                res_status = rpa_pkg::STS_ZERO;
                            end else begin
                                cnt_we    = 1'b1;
                                cnt_wdata = cnt_dec;
                                if (cnt_dec == '0 && r_top < TW'(NUM_PAGES)) begin
                                    stk_we  = 1'b1;
                                    n_top   = r_top + TW'(1);
                                    res_rel = 1'b1;
                                end else begin
                                    res_cnt = dec_ext[rpa_pkg::CNTOUT_W-1:0];
                                end
                            end
                        end
                        rpa_pkg::CMD_INC: begin
                            if (r_bad) begin
                                res_status = rpa_pkg::STS_BADADDR;
                            end else begin
                                cnt_we    = 1'b1;
                                cnt_wdata = cnt_inc;
                                res_cnt   = inc_ext[rpa_pkg::CNTOUT_W-1:0];
                            end
                        end
                        default: begin
                            // init never reaches here
                        end
                    endcase
                end
            end
            rpa_pkg::S_INIT: begin
                if (r_walk < i_lim) begin
                    cnt_we    = 1'b1;
                    cnt_waddr = r_walk[PGW-1:0];
                    stk_we    = 1'b1;
                    stk_wdata = r_walk[PGW-1:0];
                    n_top     = r_top + TW'(1);
                    n_walk    = r_walk + rpa_pkg::END_W'(1);
                end else if (out_free) begin
                    res_load = 1'b1;
                    n_state  = rpa_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = rpa_pkg::S_IDLE;
            end
        endcase
    end

    assign o_clearing    = r_state == rpa_pkg::S_CLEAR;
    assign o_out_valid   = r_out_valid;
    assign o_status      = r_status;
    assign o_page_addr   = r_page_addr;
    assign o_released    = r_released;
    assign o_count_after = r_count_after;

endmodule

// ===== hw/rtl/refcounted_page_allocator_unit.sv =====
`timescale 1ns / 1ps

// Page frame allocator with per-page reference counts and a LIFO free stack.
// Input channel: i_in_valid / o_in_stall carry one command beat (i_cmd,
// i_phys_addr). Output channel: o_out_valid / i_out_stall carry one result
// beat per command (o_status, o_page_addr, o_released, o_count_after).
// Config: i_cfg_we writes i_cfg_data to first_page (idx 0) or end_page (1);
// write only while the block is idle.
// Path: a taken command beat passes the command queue, then for alloc, free
// and inc the executor's memory read, then compute and write back to count and
// stack memories, then the result register. The executor pops a new
// command only once the last one has loaded its result. Init walks the
// managed range one page per cycle from first_page up to the limit, then
// loads its result; limit = min(end_page, NUM_PAGES).
// Reset: count memory is cleared by a pass over all NUM_PAGES pages;
// o_in_stall is high meanwhile. Stack is empty after reset.
// Receiver stall: the result register holds; the executor waits with its
// result, and the 2-deep command queue keeps taking beats until full.
module refcounted_page_allocator_unit #(
    parameter int NUM_PAGES  = rpa_pkg::NUM_PAGES_DEF,
    parameter int PAGE_SHIFT = rpa_pkg::PAGE_SHIFT_DEF,
    parameter int COUNT_BITS = rpa_pkg::COUNT_BITS_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_we,
    input  logic                         i_cfg_idx,
    input  logic [rpa_pkg::END_W-1:0]    i_cfg_data,
    input  logic                         i_in_valid,
    output logic                         o_in_stall,
    input  logic [1:0]                   i_cmd,
    input  logic [rpa_pkg::ADDR_W-1:0]   i_phys_addr,
    output logic                         o_out_valid,
    input  logic                         i_out_stall,
    output logic [1:0]                   o_status,
    output logic [rpa_pkg::ADDR_W-1:0]   o_page_addr,
    output logic                         o_released,
    output logic [rpa_pkg::CNTOUT_W-1:0] o_count_after
);

    localparam int PGW = $clog2(NUM_PAGES);
    localparam int QW  = 2 + 1 + PGW;   // cmd, bad flag, page number

    logic [1:0]                f_cmd;
    logic                      f_bad;
    logic [PGW-1:0]            f_pg;
    logic [rpa_pkg::END_W-1:0] first_page;
    logic [rpa_pkg::END_W-1:0] lim;
    logic                      q_full;
    logic                      q_empty;
    logic                      q_push;
    logic                      q_pop;
    logic [QW-1:0]             q_dout;
    logic                      clearing;

    rpa_front #(
        .NUM_PAGES  (NUM_PAGES),
        .PAGE_SHIFT (PAGE_SHIFT)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_data   (i_cfg_data),
        .i_cmd        (i_cmd),
        .i_phys_addr  (i_phys_addr),
        .o_cmd        (f_cmd),
        .o_bad        (f_bad),
        .o_pg         (f_pg),
        .o_first_page (first_page),
        .o_lim        (lim)
    );

    // no commands during the count clearing pass
    assign o_in_stall = q_full || clearing;
    assign q_push     = i_in_valid && !o_in_stall;

    rpa_queue #(
        .W (QW)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_data  ({f_cmd, f_bad, f_pg}),
        .i_pop   (q_pop),
        .o_data  (q_dout),
        .o_full  (q_full),
        .o_empty (q_empty)
    );

    rpa_back #(
        .NUM_PAGES  (NUM_PAGES),
        .PAGE_SHIFT (PAGE_SHIFT),
        .COUNT_BITS (COUNT_BITS)
    ) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_q_empty     (q_empty),
        .i_head_cmd    (q_dout[QW-1 -: 2]),
        .i_head_bad    (q_dout[PGW]),
        .i_head_pg     (q_dout[PGW-1:0]),
        .o_pop         (q_pop),
        .i_first_page  (first_page),
        .i_lim         (lim),
        .o_clearing    (clearing),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_status      (o_status),
        .o_page_addr   (o_page_addr),
        .o_released    (o_released),
        .o_count_after (o_count_after)
    );

endmodule

// ===== sim/tb.sv =====
`timescale 1ns / 1ps

import rpa_pkg::*;

typedef struct {
    t_status     sts;
    logic [31:0] page_addr;
    logic        released;
    logic [7:0]  count_after;
} t_page_result;

// Mirrors the allocator state and queues the result each command beat produces.
class page_scoreboard;
    bit [CNTEXT_W-1:0] page_refs[NUM_PAGES_DEF];
    int unsigned       page_stack[NUM_PAGES_DEF];
    int unsigned       stack_depth;
    int unsigned       first_page;
    int unsigned       end_page;
    int unsigned       owned[$];     // pages handed out, used to aim frees and incs
    t_page_result      expected_q[$];
    int                errors;
    int                reported;

    function new();
        stack_depth = 0;
        first_page  = 0;
        end_page    = END_PAGE_RST;
        errors      = 0;
        reported    = 0;
    endfunction

    function int unsigned limit();
        return (end_page < NUM_PAGES_DEF) ? end_page : NUM_PAGES_DEF;
    endfunction

    function bit in_range(int unsigned pg);
        return pg >= first_page && pg < limit();
    endfunction

    function void set_reg(logic idx, logic [END_W-1:0] value);
        if (idx == CFG_FIRST_PAGE) begin
            first_page = value[FIRST_W-1:0];
        end else begin
            end_page = value;
        end
    endfunction

    function int pending();
        return expected_q.size();
    endfunction

    function void flag(string msg);
        errors++;
        if (reported < 10) begin
            reported++;
            $display("tb: %s", msg);
        end
    endfunction

    function void push_result(t_status s, logic [31:0] pa, logic rel, int unsigned cnt);
        t_page_result r;
        r.sts         = s;
        r.page_addr   = pa;
        r.released    = rel;
        r.count_after = cnt[7:0];
        expected_q.push_back(r);
    endfunction

    // Accepted command beat: update the mirrored state, queue its result.
    function void note_cmd(t_cmd c, logic [31:0] a);
        int unsigned pg;
        int unsigned p;
        int unsigned lim;
        pg  = a >> PAGE_SHIFT_DEF;
        lim = limit();
        case (c)
            CMD_INIT: begin
                stack_depth = 0;
                for (p = first_page; p < lim; p++) begin
                    page_refs[p] = 0;
                    page_stack[stack_depth] = p;
                    stack_depth++;
                end
                push_result(STS_OK, 0, 0, 0);
            end
            CMD_ALLOC: begin
                if (stack_depth == 0) begin
                    push_result(STS_EMPTY, 0, 0, 0);
                end else begin
                    stack_depth--;
                    p = page_stack[stack_depth] % NUM_PAGES_DEF;
                    page_refs[p] = 1;
                    owned.push_back(p);
                    push_result(STS_OK, p << PAGE_SHIFT_DEF, 0, 1);
                end
            end
            CMD_FREE: begin
                if ((a & ((1 << PAGE_SHIFT_DEF) - 1)) != 0 || !in_range(pg)) begin
                    push_result(STS_BADADDR, 0, 0, 0);
                end else if (page_refs[pg] == 0) begin
                    push_result(STS_ZERO, 0, 0, 0);
                end else begin
                    page_refs[pg]--;
                    if (page_refs[pg] == 0 && stack_depth < NUM_PAGES_DEF) begin
                        page_stack[stack_depth] = pg;
                        stack_depth++;
                        push_result(STS_OK, 0, 1, 0);
                    end else begin
                        // count still above zero, or a full stack: the push is dropped
                        push_result(STS_OK, 0, 0, page_refs[pg]);
                    end
                end
            end
            default: begin
                if (!in_range(pg)) begin
                    push_result(STS_BADADDR, 0, 0, 0);
                end else begin
                    if (page_refs[pg] < (1 << COUNT_BITS_DEF) - 1)
                        page_refs[pg]++;
                    push_result(STS_OK, 0, 0, page_refs[pg]);
                end
            end
        endcase
    endfunction

    function void check_result(t_status s, logic [31:0] pa, logic rel, logic [7:0] cnt);
        t_page_result e;
        if (expected_q.size() == 0) begin
            flag($sformatf("result beat with nothing pending: sts=%0d addr=%h rel=%0d cnt=%0d",
                           s, pa, rel, cnt));
            return;
        end
        e = expected_q.pop_front();
        if (e.sts !== s || e.page_addr !== pa || e.released !== rel || e.count_after !== cnt)
            flag($sformatf({"mismatch exp sts=%0d addr=%h rel=%0d cnt=%0d, ",
                            "got sts=%0d addr=%h rel=%0d cnt=%0d"},
                           e.sts, e.page_addr, e.released, e.count_after, s, pa, rel, cnt));
    endfunction
endclass

module tb;
    localparam int HALF_PERIOD  = 4;
    localparam int LIMIT_CYCLES = 2000000;
    localparam int HOLD_CYCLES  = 400;

    logic               i_clk         = 1'b0;
    logic               i_rst_n       = 1'b0;
    logic               i_cfg_we      = 1'b0;
    logic               i_cfg_idx     = CFG_FIRST_PAGE;
    logic [END_W-1:0]   i_cfg_data    = '0;
    logic               i_in_valid    = 1'b0;
    logic               o_in_stall;
    logic [1:0]         i_cmd         = CMD_INIT;
    logic [ADDR_W-1:0]  i_phys_addr   = '0;
    logic               o_out_valid;
    logic               i_out_stall   = 1'b0;
    logic [1:0]         o_status;
    logic [ADDR_W-1:0]  o_page_addr;
    logic               o_released;
    logic [CNTOUT_W-1:0] o_count_after;

    page_scoreboard sb;
    bit             calm = 1'b0;      // no idling on either side while set
    int             holds_requested = 0;
    int             holds_served = 0;
    int             hold_left = 0;
    int unsigned    cycle_count = 0;

    always #(HALF_PERIOD) i_clk = ~i_clk;

    refcounted_page_allocator_unit uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_cmd         (i_cmd),
        .i_phys_addr   (i_phys_addr),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_status      (o_status),
        .o_page_addr   (o_page_addr),
        .o_released    (o_released),
        .o_count_after (o_count_after)
    );

    // Result side: random stall, none while calm, and a long hold-off on request
    // so the command queue fills and the block stalls its input.
    always @(posedge i_clk) begin
        if (holds_served != holds_requested) begin
            holds_served++;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= !calm && ($urandom_range(99) < 34);
        end
    end

    // Result beats are taken on edges with valid high and stall low.
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall)
            sb.check_result(t_status'(o_status), o_page_addr, o_released, o_count_after);
    end

    // Watchdog; covers the reset clearing pass and full-range inits.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= LIMIT_CYCLES) begin
            $display("tb: done, errors");
            $finish;
        end
    end

    task automatic idle_gap(int n);
        i_in_valid <= 1'b0;
        repeat (n) @(posedge i_clk);
    endtask

    // One command beat, noted at the edge that took it; unless calm, sometimes followed by an idle gap.
    task automatic send_beat(t_cmd c, logic [31:0] a);
        i_in_valid  <= 1'b1;
        i_cmd       <= c;
        i_phys_addr <= a;
        do @(posedge i_clk); while (o_in_stall);
        sb.note_cmd(c, a);
        if (!calm && $urandom_range(99) < 34)
            idle_gap($urandom_range(4, 1));
    endtask

    // Sender pauses until every pending result beat is back.
    task automatic wait_idle();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (sb.pending() != 0);
    endtask

    task automatic set_range(logic [END_W-1:0] first, logic [END_W-1:0] last);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= CFG_FIRST_PAGE;
        i_cfg_data <= first;
        @(posedge i_clk);
        sb.set_reg(CFG_FIRST_PAGE, first);
        i_cfg_idx  <= CFG_END_PAGE;
        i_cfg_data <= last;
        @(posedge i_clk);
        sb.set_reg(CFG_END_PAGE, last);
        i_cfg_we   <= 1'b0;
    endtask

    // Mostly pages inside the range or already handed out; some edges and noise.
    function automatic logic [31:0] page_target();
        int unsigned r;
        int unsigned pg;
        int unsigned hi;
        logic [31:0] a;
        r  = $urandom_range(99);
        hi = sb.limit();
        if (r < 10)
            return $urandom();
        if (r >= 90 && r < 95)
            pg = (sb.first_page > 0 && $urandom_range(1)) ? sb.first_page - 1 : hi;
        else if (r < 50 && sb.owned.size() > 0)
            pg = sb.owned[$urandom_range(sb.owned.size() - 1)];
        else if (hi > sb.first_page)
            pg = $urandom_range(hi - 1, sb.first_page);
        else
            pg = $urandom_range(NUM_PAGES_DEF - 1);
        a = pg << PAGE_SHIFT_DEF;
        if (r >= 95)
            a[PAGE_SHIFT_DEF-1:0] = $urandom_range(4095, 1);
        return a;
    endfunction

    task automatic random_item();
        int unsigned r;
        r = $urandom_range(99);
        if (r < 3)
            send_beat(CMD_INIT, $urandom());
        else if (r < 40)
            send_beat(CMD_ALLOC, $urandom());
        else if (r < 72)
            send_beat(CMD_FREE, page_target());
        else
            send_beat(CMD_INC, page_target() | ($urandom_range(1) ? $urandom_range(4095) : 0));
    endtask

    initial begin
        int unsigned lo;
        int          ph;
        sb = new();
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: default range, empty stack and error paths first.
        send_beat(CMD_ALLOC, 32'h0);                  // empty stack
        send_beat(CMD_FREE, 32'h0);                   // count already zero
        send_beat(CMD_INC, 32'hFFFF_FFFF);            // top page, out of range
        send_beat(CMD_FREE, 32'h0000_0001);           // not aligned
        send_beat(CMD_INIT, 32'h0);                   // fills the whole stack
        // page on the full stack raised and freed: push is dropped
        send_beat(CMD_INC, 32'h0000_5ABC);
        send_beat(CMD_FREE, 32'h0000_5000);
        send_beat(CMD_ALLOC, 32'hFFFF_FFFF);          // highest page first
        send_beat(CMD_INC, 32'h07FF_F000);
        send_beat(CMD_FREE, 32'h07FF_F000);
        send_beat(CMD_FREE, 32'h07FF_F000);           // released
        send_beat(CMD_FREE, 32'h07FF_F000);           // count already zero
        send_beat(CMD_FREE, 32'h0800_0000);           // page at the limit, just out of range
        // range moved to first_page at its register maximum: the stack keeps its pages
        wait_idle();
        set_range(21'd1048575, 21'd1048576);
        send_beat(CMD_ALLOC, 32'h0);
        send_beat(CMD_INIT, 32'h0);                   // empty range
        send_beat(CMD_ALLOC, 32'h0);
        send_beat(CMD_INC, 32'h0000_1000);
        send_beat(CMD_FREE, 32'h0);
        wait_idle();
        set_range(21'd0, 21'd0);
        send_beat(CMD_INIT, 32'h0);
        wait_idle();
        set_range(21'd10, 21'd14);
        send_beat(CMD_INIT, 32'h0);
        send_beat(CMD_ALLOC, 32'h0);
        send_beat(CMD_ALLOC, 32'h0);
        send_beat(CMD_FREE, 32'h0000_D000);
        send_beat(CMD_INC, 32'h0000_CFFF);

        // Random phases: each starts idle with a fresh range and an init.
        for (ph = 0; ph < 6; ph++) begin
            wait_idle();
            case (ph)
                0: set_range(21'd0, 21'd40);
                3: set_range(21'd32700, 21'd1048576);
                default: begin
                    lo = $urandom_range(32700);
                    set_range(lo, lo + $urandom_range(64, 1));
                end
            endcase
            calm = (ph == 2);
            if (ph == 4)
                holds_requested++;
            send_beat(CMD_INIT, $urandom());
            repeat (60) random_item();
        end

        // One page driven into count saturation and partly back down.
        wait_idle();
        calm = 1'b0;
        set_range(21'd100, 21'd104);
        send_beat(CMD_INIT, 32'h0);
        send_beat(CMD_ALLOC, 32'h0);                  // page 103
        repeat (258) send_beat(CMD_INC, (32'd103 << PAGE_SHIFT_DEF) | $urandom_range(4095));
        repeat (3) send_beat(CMD_FREE, 32'd103 << PAGE_SHIFT_DEF);

        wait_idle();
        repeat (20) @(posedge i_clk);
        if (sb.pending() != 0)
            sb.flag($sformatf("%0d result beats never arrived", sb.pending()));
        if (sb.errors == 0) begin
            $display("tb: done, clean");
        end else begin
            $display("tb: done, errors");
        end
        $finish;
    end
endmodule
